// ===== rtl/core/delta_list_task_scheduler_assert.svh =====
// assertion macros for the delta list task scheduler
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH
`define DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define DLTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlts same-cycle check failed");
`define DLTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlts next-cycle check failed");
`else
`define DLTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/dlts_pkg.sv =====
// shared types and constants for the delta list task scheduler
// no dependencies
`default_nettype none

package dlts_pkg;

  localparam int unsigned TICK_LEN_W = 10;
  localparam logic [TICK_LEN_W-1:0] TICK_LEN_RST = 10'd10;
  localparam logic [7:0] DUE_MAX = 8'hFF;
  localparam logic [4:0] DIV_LAST = 5'd31;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_POLL = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  task_handle;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [7:0] fired_handle;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] delta;
    logic [31:0] period;
    logic [7:0]  due;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/dlts_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module dlts_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/delta_list_task_scheduler.sv =====
// delta list task scheduler top level: sequencer, shared divider and entry list
// depends on dlts_pkg, dlts_ram and delta_list_task_scheduler_assert.svh
//
// usage: one request on in_data (valid/stall) carries a command: add a task,
// timer tick or dispatch poll. every request gives exactly one response on
// out_data (valid/stall) with status, fired flag and fired handle.
// a new request is taken only while the sequencer is idle; in_stall is high
// for the whole of a request's work. a finished response waits in the output
// register, so the next request can be taken while the receiver stalls; the
// sequencer then holds its result until the output register is free.
// work per request (N = live entries, one ram port pair, registered read):
//   tick, or poll with nothing due: one read of the head, none on an empty list
//   add: two divisions (delay, period) through the one divider, a walk over the
//        entries passed, a move of the entries behind the gap and the insert;
//        turned away at once when the list is full
//   firing poll: other N-1 entries move up; periodic: walk, move and insert
// cfg_we/cfg_wdata write the tick length; 0 counts as 1. the user must write
// it only while idle; the block itself does not enforce this.
// reset (rst_n low, synchronous) empties the list, sets tick length to 10
// and drops any pending response; the entry ram needs no clearing pass.
`default_nettype none

module delta_list_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire dlts_pkg::req_t              in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output dlts_pkg::rsp_t                   out_data,
  input  wire logic                        cfg_we,
  input  wire logic [dlts_pkg::TICK_LEN_W-1:0] cfg_wdata
);

  import dlts_pkg::*;

  `include "delta_list_task_scheduler_assert.svh"

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = $clog2(MAX_TASKS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WALK_RD, S_WALK_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_INSERT, S_TICK, S_POLL, S_DROP_RD, S_DROP_WR, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  req_t                    req_r, req_nxt;
  rsp_t                    res_r, res_nxt;
  rsp_t                    out_data_r, out_data_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TICK_LEN_W-1:0]   tick_len_r, tick_len_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [31:0]             quo_r, quo_nxt;
  logic [TICK_LEN_W-1:0]   rem_r, rem_nxt;
  logic [4:0]              div_cnt_r, div_cnt_nxt;
  logic                    div_sel_r, div_sel_nxt;
  entry_t                  ins_r, ins_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_raddr;
  entry_t                  ram_wdata;
  entry_t                  ram_rdata;

  logic [TICK_LEN_W-1:0]   divisor;
  logic [TICK_LEN_W:0]     rem_sh;
  logic [TICK_LEN_W:0]     rem_sub;
  logic                    rem_ge;
  logic [31:0]             quo_step;
  logic [CNT_W-1:0]        pos_inc;
  logic [CNT_W-1:0]        k_inc;
  logic [CNT_W-1:0]        k_dec;
  logic                    list_full;
  entry_t                  ent;

  dlts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // restoring divider, one quotient bit per cycle
  assign divisor  = (tick_len_r == '0) ? TICK_LEN_W'(1) : tick_len_r;
  assign rem_sh   = {rem_r, quo_r[31]};
  assign rem_ge   = rem_sh >= {1'b0, divisor};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign quo_step = {quo_r[30:0], rem_ge};

  assign pos_inc   = pos_r + CNT_W'(1);
  assign k_inc     = k_r + CNT_W'(1);
  assign k_dec     = k_r - CNT_W'(1);
  assign list_full = count_r == CNT_W'(MAX_TASKS);

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tick_len_nxt  = cfg_we ? cfg_wdata : tick_len_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    div_sel_nxt   = div_sel_r;
    ins_nxt       = ins_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = '0;
    ram_wdata     = ram_rdata;
    ent           = ram_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '{status: ST_DONE, fired: 1'b0, fired_handle: 8'd0};
          unique case (in_data.command)
            CMD_ADD: begin
              if (list_full) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                quo_nxt     = in_data.delay_ms;
                rem_nxt     = '0;
                div_cnt_nxt = '0;
                div_sel_nxt = 1'b0;
                state_nxt   = S_DIV;
              end
            end
            CMD_TICK: begin
              state_nxt = (count_r == '0) ? S_DONE : S_TICK;
            end
            CMD_POLL: begin
              if (count_r == '0) begin
                res_nxt.status = ST_NONE;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_POLL;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_DIV: begin
        quo_nxt     = quo_step;
        rem_nxt     = rem_ge ? rem_sub[TICK_LEN_W-1:0] : rem_sh[TICK_LEN_W-1:0];
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == DIV_LAST) begin
          if (!div_sel_r) begin
            ins_nxt.delta = quo_step;
            quo_nxt       = req_r.period_ms;
            rem_nxt       = '0;
            div_cnt_nxt   = '0;
            div_sel_nxt   = 1'b1;
          end else begin
            ins_nxt.period = quo_step;
            ins_nxt.handle = req_r.task_handle;
            ins_nxt.due    = 8'd0;
            pos_nxt        = '0;
            state_nxt      = S_WALK_RD;
          end
        end
      end

      S_TICK: begin
        if (ram_rdata.delta != 32'd0) begin
          ent.delta = ram_rdata.delta - 32'd1;
        end else if (ram_rdata.due != DUE_MAX) begin
          ent.due = ram_rdata.due + 8'd1;
        end
        ram_we    = 1'b1;
        ram_wdata = ent;
        state_nxt = S_DONE;
      end

      S_POLL: begin
        if (ram_rdata.due == 8'd0) begin
          res_nxt.status = ST_NONE;
          state_nxt      = S_DONE;
        end else begin
          res_nxt.fired        = 1'b1;
          res_nxt.fired_handle = ram_rdata.handle;
          ins_nxt.handle       = ram_rdata.handle;
          ins_nxt.delta        = ram_rdata.period;
          ins_nxt.period       = ram_rdata.period;
          ins_nxt.due          = ram_rdata.due - 8'd1;
          k_nxt                = '0;
          state_nxt            = S_DROP_RD;
        end
      end

      // move every entry behind the head one place towards the head
      S_DROP_RD: begin
        if (k_inc < count_r) begin
          ram_raddr = k_inc[IDX_W-1:0];
          state_nxt = S_DROP_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          pos_nxt   = '0;
          state_nxt = (ins_r.period != 32'd0) ? S_WALK_RD : S_DONE;
        end
      end

      S_DROP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_inc;
        state_nxt = S_DROP_RD;
      end

      // find the insertion point, consuming deltas on the way
      S_WALK_RD: begin
        if (pos_r < count_r) begin
          ram_raddr = pos_r[IDX_W-1:0];
          state_nxt = S_WALK_CMP;
        end else begin
          k_nxt     = count_r;
          state_nxt = S_SHIFT_RD;
        end
      end

      S_WALK_CMP: begin
        if (ram_rdata.delta <= ins_r.delta) begin
          ins_nxt.delta = ins_r.delta - ram_rdata.delta;
          pos_nxt       = pos_inc;
          state_nxt     = S_WALK_RD;
        end else begin
          k_nxt     = count_r;
          state_nxt = S_SHIFT_RD;
        end
      end

      // open a gap at the insertion point, tail first
      S_SHIFT_RD: begin
        if (k_r > pos_r) begin
          ram_raddr = k_dec[IDX_W-1:0];
          state_nxt = S_SHIFT_WR;
        end else begin
          state_nxt = S_INSERT;
        end
      end

      S_SHIFT_WR: begin
        if (k_r == pos_inc) begin
          ent.delta = ram_rdata.delta - ins_r.delta;
        end
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        ram_wdata = ent;
        k_nxt     = k_dec;
        state_nxt = S_SHIFT_RD;
      end

      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[IDX_W-1:0];
        ram_wdata = ins_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tick_len_r  <= TICK_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tick_len_r  <= tick_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_sel_r  <= div_sel_nxt;
    ins_r      <= ins_nxt;
  end

  `DLTS_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_TASKS))
  `DLTS_ASSERT_NXT(a_full_add_keeps, clk, rst_n, in_valid && !in_stall && in_data.command == CMD_ADD && list_full, count_r == $past(count_r))
  `DLTS_ASSERT_IMP(a_ram_write_live, clk, rst_n, ram_we, CNT_W'(ram_waddr) <= count_r)
  `DLTS_ASSERT_IMP(a_fired_status, clk, rst_n, out_valid_r && !out_data_r.fired, out_data_r.fired_handle == 8'd0)

endmodule

`default_nettype wire

// ===== tb/delta_list_task_scheduler_tb.sv =====
// self-checking testbench for the delta list task scheduler: add, tick and dispatch requests
// with random idling on both channels, checked against a queue-based model of the task list
// depends on dlts_pkg and delta_list_task_scheduler
`timescale 1ns / 1ps

module delta_list_task_scheduler_tb;
  import dlts_pkg::*;

  localparam int MAX_TASKS = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_CYCLES = 150;
  localparam int PHASE_ITEMS = 170;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [TICK_LEN_W-1:0] cfg_wdata = '0;

  // model of the scheduler
  entry_t task_list[$];
  logic [TICK_LEN_W-1:0] tick_len_ms = TICK_LEN_RST;
  rsp_t rsp_expected[$];

  req_t pending_reqs[$];
  logic req_taken = 1'b0;
  bit idle_enable = 1'b1;
  int in_gap = 0;
  int out_gap = 0;
  int lasting_tasks = 0;
  int mismatches = 0;
  int accepted_requests = 0;
  int fired_tasks = 0;
  int rejected_adds = 0;
  logic [TICK_LEN_W-1:0] tick_settings[7];

  delta_list_task_scheduler #(
    .MAX_TASKS(MAX_TASKS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void place_task(logic [7:0] handle, logic [31:0] delay,
                                     logic [31:0] period, logic [7:0] due);
    int pos;
    entry_t e;
    if (task_list.size() >= MAX_TASKS) return;
    pos = 0;
    while (pos < task_list.size() && task_list[pos].delta <= delay) begin
      delay = delay - task_list[pos].delta;
      pos++;
    end
    // only the entry that ends up behind the new one gives up the remainder
    if (pos < task_list.size()) begin
      e = task_list[pos];
      e.delta = e.delta - delay;
      task_list[pos] = e;
    end
    e.handle = handle;
    e.delta = delay;
    e.period = period;
    e.due = due;
    task_list.insert(pos, e);
  endfunction

  function automatic void predict_request(req_t r);
    rsp_t rsp;
    entry_t head;
    logic [31:0] divisor;
    rsp.status = ST_DONE;
    rsp.fired = 1'b0;
    rsp.fired_handle = 8'h00;
    divisor = (tick_len_ms == '0) ? 32'd1 : 32'(tick_len_ms);
    accepted_requests++;
    case (r.command)
      CMD_ADD: begin
        if (task_list.size() >= MAX_TASKS) begin
          rsp.status = ST_FULL;
          rejected_adds++;
        end else begin
          place_task(r.task_handle, r.delay_ms / divisor, r.period_ms / divisor, 8'h00);
        end
      end
      CMD_TICK: begin
        if (task_list.size() > 0) begin
          head = task_list[0];
          if (head.delta != 0) head.delta = head.delta - 32'd1;
          else if (head.due != DUE_MAX) head.due = head.due + 8'd1;
          task_list[0] = head;
        end
      end
      CMD_POLL: begin
        if (task_list.size() > 0 && task_list[0].due != 0) begin
          head = task_list[0];
          task_list.delete(0);
          if (head.period != 0)
            place_task(head.handle, head.period, head.period, head.due - 8'd1);
          rsp.fired = 1'b1;
          rsp.fired_handle = head.handle;
          fired_tasks++;
        end else begin
          rsp.status = ST_NONE;
        end
      end
      default: ;
    endcase
    rsp_expected.push_back(rsp);
  endfunction

  function automatic void check_response(rsp_t got);
    rsp_t want;
    if (rsp_expected.size() == 0) begin
      $display("%0t: response with nothing outstanding, actual status %0d fired %0d handle %0d",
               $time, got.status, got.fired, got.fired_handle);
      mismatches++;
      return;
    end
    want = rsp_expected.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.fired !== want.fired) begin
      $display("%0t: fired mismatch, expected %0d actual %0d", $time, want.fired, got.fired);
      mismatches++;
    end
    if (got.fired_handle !== want.fired_handle) begin
      $display("%0t: fired_handle mismatch, expected %0d actual %0d",
               $time, want.fired_handle, got.fired_handle);
      mismatches++;
    end
  endfunction

  // request side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // held until taken
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_gap <= $urandom_range(0, 3);
    end else if (pending_reqs.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= pending_reqs.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // response side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else if (idle_enable && !out_stall && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      out_gap <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_request(in_data);
      if (out_valid && !out_stall) check_response(out_data);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, quiet);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_req(input logic [1:0] cmd, input logic [7:0] handle,
                          input logic [31:0] delay, input logic [31:0] period);
    req_t r;
    r.command = cmd;
    r.task_handle = handle;
    r.delay_ms = delay;
    r.period_ms = period;
    pending_reqs.push_back(r);
  endtask

  task automatic push_noise_cmd(input logic [1:0] cmd);
    push_req(cmd, 8'($urandom), $urandom, $urandom);
  endtask

  task automatic wait_for_drain;
    while (pending_reqs.size() != 0 || rsp_expected.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic write_tick_length(input logic [TICK_LEN_W-1:0] value);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tick_len_ms = value;
  endtask

  task automatic queue_directed;
    int i;
    push_req(CMD_TICK, 8'h00, 32'h0, 32'h0);
    push_req(CMD_POLL, 8'h00, 32'h0, 32'h0);
    push_req(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(CMD_ADD, 8'h00, 32'h0, 32'h0);
    // zero delay but not yet ticked: nothing due
    push_req(CMD_POLL, 8'h00, 32'h0, 32'h0);
    push_req(CMD_TICK, 8'h00, 32'h0, 32'h0);
    push_req(CMD_POLL, 8'h00, 32'h0, 32'h0);
    // fill the list, with ties and periods shorter than one tick
    for (i = 1; i <= 15; i++) begin
      push_req(CMD_ADD, 8'(i), 32'((i % 5) * 10 + (i % 3)),
               (i % 4 == 0) ? 32'd20 : ((i % 3 == 0) ? 32'd5 : 32'd0));
    end
    push_req(CMD_ADD, 8'h80, 32'd0, 32'd0);
    lasting_tasks = 4;
  endtask

  task automatic queue_random(input int count, input bit saturate);
    int made, k, runlen, kind, pick, div;
    logic [31:0] dly, per;
    div = (tick_len_ms == '0) ? 1 : int'(tick_len_ms);
    made = 0;
    if (saturate) begin
      // a zero-delay periodic task keeps firing while the head's due count pins at its ceiling
      push_req(CMD_ADD, 8'($urandom), 32'd0, 32'(div));
      lasting_tasks++;
      for (k = 0; k < 260; k++) push_noise_cmd(CMD_TICK);
      for (k = 0; k < 4; k++) push_noise_cmd(CMD_POLL);
    end
    while (made < count) begin
      kind = $urandom_range(0, 99);
      runlen = 1;
      if (kind < 30) begin
        runlen = $urandom_range(1, 3);
        for (k = 0; k < runlen; k++) begin
          dly = $urandom_range(0, 12 * div);
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            per = 32'd0;
          end else if (pick < 90) begin
            per = $urandom_range(0, div - 1);
          end else if (lasting_tasks < 9) begin
            per = $urandom_range(1, 10) * div + $urandom_range(0, div - 1);
            lasting_tasks++;
          end else begin
            per = 32'd0;
          end
          push_req(CMD_ADD, 8'($urandom), dly, per);
        end
      end else if (kind < 62) begin
        runlen = $urandom_range(1, 8);
        for (k = 0; k < runlen; k++) push_noise_cmd(CMD_TICK);
      end else if (kind < 92) begin
        runlen = $urandom_range(1, 3);
        for (k = 0; k < runlen; k++) push_noise_cmd(CMD_POLL);
      end else if (kind < 97) begin
        push_noise_cmd(CMD_UNUSED);
      end else if (lasting_tasks < 9) begin
        push_req(CMD_ADD, 8'($urandom), $urandom, $urandom);
        lasting_tasks++;
      end else begin
        push_noise_cmd(CMD_POLL);
      end
      made += runlen;
    end
  endtask

  initial begin
    int p;
    tick_settings[0] = 10'd1;
    tick_settings[1] = 10'd1023;
    tick_settings[2] = 10'd0;
    tick_settings[3] = 10'd1000;
    tick_settings[4] = 10'($urandom_range(2, 999));
    tick_settings[5] = 10'($urandom_range(2, 999));
    tick_settings[6] = TICK_LEN_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    queue_directed();
    for (p = 0; p < 7; p++) begin
      wait_for_drain();
      write_tick_length(tick_settings[p]);
      if (p == 6) idle_enable = 1'b0;
      queue_random(PHASE_ITEMS, p == 1 || p == 4);
    end
    wait_for_drain();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d requests over seven tick lengths incl. 0, 1, 1000 and 1023",
             accepted_requests);
    $display("%0d tasks released, %0d adds turned away on a full list",
             fired_tasks, rejected_adds);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
